FILE: rtl/grlc_pkg.sv
// Package with the shared types and constants of the glyph run layout clipper.
package grlc_pkg;

    localparam int GLYPH_ENTRIES = 128;
    localparam int GLYPH_IDX_W   = $clog2(GLYPH_ENTRIES);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [16:0] TEX_S_MAX = 17'h1FFFF;
    localparam logic signed [17:0] PEN_MAX = 18'sh1FFFF;
    localparam logic signed [17:0] PEN_MIN = -18'sh20000;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_CHAR  = 2'd2,
        ACT_END   = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCALE_X       = 3'd0,
        REG_SCALE_Y       = 3'd1,
        REG_LINE_HEIGHT   = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4,
        REG_TEX_STEP_X    = 3'd5,
        REG_TEX_STEP_Y    = 3'd6,
        REG_UNUSED        = 3'd7
    } cfg_reg_t;

    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_PEN  = 1'b1;

    typedef struct packed {
        logic [7:0]        width;
        logic signed [7:0] kerning;
        logic [9:0]        left;
        logic [9:0]        top;
    } glyph_entry_t;

endpackage

FILE: rtl/glyph_run_layout_clipper.sv
// Top level of the glyph run layout clipper: glyph table, pen state and result register.
//
// The block takes one transaction per cycle while s_ready is high: the input stage
// reads the glyph table memory (registered read), then the scale multiply, clipping
// and pen update load the result register, which holds the answer. Loads,
// begins and absent glyphs give no result; end returns the pen. While a result
// waits in the result register the block takes one more transaction into its
// input stage and then holds s_ready low until the result is taken. Configuration
// writes take effect at once and are expected only while the block is idle. The
// texture step registers are accepted but do not affect any result.
module glyph_run_layout_clipper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [grlc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [grlc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [6:0]                      s_char_code,
    input  logic                            s_glyph_present,
    input  logic [7:0]                      s_glyph_width,
    input  logic signed [7:0]               s_glyph_kerning,
    input  logic [9:0]                      s_glyph_left,
    input  logic [9:0]                      s_glyph_top,
    input  logic signed [10:0]              s_start_x,
    input  logic signed [10:0]              s_start_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [11:0]                     m_rect_left,
    output logic signed [12:0]              m_rect_top,
    output logic [11:0]                     m_rect_right,
    output logic signed [12:0]              m_rect_bottom,
    output logic [16:0]                     m_tex_s,
    output logic [14:0]                     m_tex_t,
    output logic signed [17:0]              m_pen_x
);

    // Configuration registers.
    logic [11:0] scale_x_reg;
    logic [11:0] scale_y_reg;
    logic [7:0]  line_height_reg;
    logic [9:0]  screen_width_reg;
    logic [9:0]  screen_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg       <= 12'd256;
            scale_y_reg       <= 12'd256;
            line_height_reg   <= 8'd16;
            screen_width_reg  <= 10'd320;
            screen_height_reg <= 10'd240;
        end else if (cfg_wr_en) begin
            case (grlc_pkg::cfg_reg_t'(cfg_index))
                grlc_pkg::REG_SCALE_X:       scale_x_reg       <= cfg_wr_data[11:0];
                grlc_pkg::REG_SCALE_Y:       scale_y_reg       <= cfg_wr_data[11:0];
                grlc_pkg::REG_LINE_HEIGHT:   line_height_reg   <= cfg_wr_data[7:0];
                grlc_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data[9:0];
                grlc_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake control.
    logic s1_valid_reg;
    logic s1_fire;
    logic s_fire;
    logic emit;

    assign s1_fire = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    // Glyph table: present bits in flip-flops, entry data in a memory.
    logic [grlc_pkg::GLYPH_ENTRIES-1:0] present_reg;
    grlc_pkg::glyph_entry_t glyph_mem [grlc_pkg::GLYPH_ENTRIES];
    logic [grlc_pkg::GLYPH_IDX_W-1:0] s_idx;
    logic s_in_range;
    logic s_load;

    assign s_idx      = grlc_pkg::GLYPH_IDX_W'(s_char_code);
    assign s_in_range = 32'(s_char_code) < grlc_pkg::GLYPH_ENTRIES;
    assign s_load     = s_fire && (grlc_pkg::action_t'(s_action) == grlc_pkg::ACT_LOAD)
                        && s_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else if (s_load) begin
            present_reg[s_idx] <= s_glyph_present;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_load) begin
            glyph_mem[s_idx] <= '{width: s_glyph_width, kerning: s_glyph_kerning,
                                  left: s_glyph_left, top: s_glyph_top};
        end
    end

    // Input register stage with the registered table read.
    grlc_pkg::action_t      s1_action_reg;
    logic signed [10:0]     s1_start_x_reg;
    logic signed [10:0]     s1_start_y_reg;
    grlc_pkg::glyph_entry_t rd_entry_reg;
    logic                   rd_present_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_action_reg  <= grlc_pkg::action_t'(s_action);
            s1_start_x_reg <= s_start_x;
            s1_start_y_reg <= s_start_y;
            rd_entry_reg   <= glyph_mem[s_idx];
            rd_present_reg <= present_reg[s_idx] && s_in_range;
        end
    end

    // Pen and line state.
    logic signed [17:0] pen_reg;
    logic signed [17:0] pen_next;
    logic signed [12:0] line_top_reg;
    logic signed [12:0] line_top_next;
    logic signed [12:0] line_bottom_reg;
    logic signed [12:0] line_bottom_next;
    logic               line_visible_reg;
    logic               line_visible_next;

    // Begin arithmetic.
    logic [19:0]        height_prod;
    logic signed [12:0] begin_top;
    logic signed [15:0] begin_bottom;
    logic signed [15:0] bottom_limit;
    logic signed [15:0] begin_bottom_clamped;

    assign height_prod  = 20'(line_height_reg) * 20'(scale_y_reg);
    assign begin_top    = {s1_start_y_reg, 2'b00};
    assign begin_bottom = 16'(begin_top) + $signed({2'b00, height_prod[19:6]});
    assign bottom_limit = $signed({4'b0000, screen_height_reg, 2'b00});
    assign begin_bottom_clamped = (begin_bottom > bottom_limit) ? bottom_limit : begin_bottom;

    // Character arithmetic.
    logic [19:0]        width_prod;
    logic [16:0]        scaled_width;
    logic signed [21:0] adv_width;
    logic signed [21:0] adv_prod;
    logic signed [18:0] advance;
    logic signed [19:0] pen_sum;
    logic signed [18:0] right_raw;
    logic signed [18:0] right_limit;
    logic signed [18:0] right_clip;
    logic [17:0]        clip_offset;
    logic [13:0]        left_q;
    logic [11:0]        right_q;
    logic [18:0]        tex_s_sum;
    logic [16:0]        tex_s_sat;
    logic               is_char;

    assign width_prod   = 20'(rd_entry_reg.width) * 20'(scale_x_reg);
    assign scaled_width = width_prod[19:3];
    assign adv_width    = $signed({14'd0, rd_entry_reg.width}) + 22'(rd_entry_reg.kerning);
    assign adv_prod     = adv_width * $signed({10'd0, scale_x_reg});
    assign advance      = adv_prod[21:3];

    assign right_raw   = 19'(pen_reg) + $signed({2'b00, scaled_width});
    assign right_limit = $signed({4'd0, screen_width_reg, 5'd0});
    assign right_clip  = (right_raw > right_limit) ? right_limit : right_raw;
    assign clip_offset = pen_reg[17] ? 18'(-pen_reg) : 18'd0;
    assign left_q      = pen_reg[17] ? 14'd0 : pen_reg[16:3];
    assign right_q     = right_clip[14:3];
    assign tex_s_sum   = {4'd0, rd_entry_reg.left, 5'd0} + {1'b0, clip_offset};
    assign tex_s_sat   = (tex_s_sum > 19'(grlc_pkg::TEX_S_MAX)) ? grlc_pkg::TEX_S_MAX
                                                                : tex_s_sum[16:0];

    assign is_char = (s1_action_reg == grlc_pkg::ACT_CHAR) && rd_present_reg;

    always_comb begin
        if (line_visible_reg) begin
            pen_sum = 20'(pen_reg) + 20'(advance);
        end else begin
            pen_sum = 20'(pen_reg) + $signed({3'b000, scaled_width});
        end
    end

    always_comb begin
        pen_next          = pen_reg;
        line_top_next     = line_top_reg;
        line_bottom_next  = line_bottom_reg;
        line_visible_next = line_visible_reg;
        emit              = 1'b0;
        case (s1_action_reg)
            grlc_pkg::ACT_BEGIN: begin
                pen_next          = 18'($signed({s1_start_x_reg, 5'd0}));
                line_top_next     = begin_top;
                line_bottom_next  = begin_bottom_clamped[12:0];
                line_visible_next = begin_bottom_clamped > 16'(begin_top);
            end
            grlc_pkg::ACT_CHAR: begin
                if (is_char) begin
                    if (pen_sum > 20'(grlc_pkg::PEN_MAX)) begin
                        pen_next = grlc_pkg::PEN_MAX;
                    end else if (pen_sum < 20'(grlc_pkg::PEN_MIN)) begin
                        pen_next = grlc_pkg::PEN_MIN;
                    end else begin
                        pen_next = pen_sum[17:0];
                    end
                    emit = line_visible_reg && !right_clip[18] && (left_q < {2'b00, right_q});
                end
            end
            grlc_pkg::ACT_END: begin
                emit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg          <= '0;
            line_top_reg     <= '0;
            line_bottom_reg  <= '0;
            line_visible_reg <= 1'b0;
        end else if (s1_fire) begin
            pen_reg          <= pen_next;
            line_top_reg     <= line_top_next;
            line_bottom_reg  <= line_bottom_next;
            line_visible_reg <= line_visible_next;
        end
    end

    // Result register.
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && emit) begin
            if (s1_action_reg == grlc_pkg::ACT_END) begin
                m_kind        <= grlc_pkg::KIND_PEN;
                m_rect_left   <= '0;
                m_rect_top    <= '0;
                m_rect_right  <= '0;
                m_rect_bottom <= '0;
                m_tex_s       <= '0;
                m_tex_t       <= '0;
                m_pen_x       <= pen_reg;
            end else begin
                m_kind        <= grlc_pkg::KIND_RECT;
                m_rect_left   <= left_q[11:0];
                m_rect_top    <= line_top_reg;
                m_rect_right  <= right_q;
                m_rect_bottom <= line_bottom_reg;
                m_tex_s       <= tex_s_sat;
                m_tex_t       <= {rd_entry_reg.top, 5'd0};
                m_pen_x       <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/grlc_checker.sv
// Port-level checker for the glyph run layout clipper and its bind statement.
module grlc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_kind,
    input logic [11:0]        m_rect_left,
    input logic signed [12:0] m_rect_top,
    input logic [11:0]        m_rect_right,
    input logic signed [12:0] m_rect_bottom,
    input logic [16:0]        m_tex_s,
    input logic [14:0]        m_tex_t,
    input logic signed [17:0] m_pen_x
);

    // A stalled result transaction keeps its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_pen_x)
            && $stable(m_rect_left) && $stable(m_rect_right) && $stable(m_tex_s))
        else $error("result transaction changed while stalled");

    // A rectangle always has positive width after clipping.
    a_rect_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == grlc_pkg::KIND_RECT) |-> m_rect_left < m_rect_right)
        else $error("empty rectangle emitted");

    // A rectangle comes only from a visible line, whose bottom lies below its top.
    a_rect_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == grlc_pkg::KIND_RECT) |-> m_rect_top < m_rect_bottom
            && m_pen_x == 18'sd0)
        else $error("rectangle from an invisible line");

    // A pen result carries nothing but the pen.
    a_pen_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == grlc_pkg::KIND_PEN) |-> m_rect_left == 12'd0
            && m_rect_right == 12'd0 && m_rect_top == 13'sd0 && m_rect_bottom == 13'sd0
            && m_tex_s == 17'd0 && m_tex_t == 15'd0)
        else $error("pen result with rectangle fields set");

endmodule

bind glyph_run_layout_clipper grlc_checker u_grlc_checker (.*);
